// ===== hdl/assert_macros.svh =====
// assertion macros used by the decoder back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/u8d_pkg.sv =====
// types and constants shared by the utf-8 decoder modules
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned BITS_W = 7;

    // byte class decided in the front end
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } cls_t;

    // one classified byte as it travels through the queue
    typedef struct packed {
        cls_t              cls;
        logic [BITS_W-1:0] bits;
        logic              eos;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/u8d_front.sv =====
// front end: holds the four-byte enable and classifies each incoming byte
`default_nettype none

module u8d_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_allow_four_byte,
    input  wire logic [u8d_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       end_of_string,
    output u8d_pkg::entry_t                 entry
);

    logic allow_four_byte_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_four_byte_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            allow_four_byte_reg <= cfg_allow_four_byte;
        end
    end

    always_comb
    begin
        entry.eos  = end_of_string;
        entry.cls  = u8d_pkg::CLS_BAD;
        entry.bits = '0;
        case (data_byte) inside
            8'b0???????:
            begin
                entry.cls  = u8d_pkg::CLS_ASCII;
                entry.bits = data_byte[6:0];
            end
            8'b10??????:
            begin
                entry.cls  = u8d_pkg::CLS_CONT;
                entry.bits = {1'b0, data_byte[5:0]};
            end
            8'b110?????:
            begin
                entry.cls  = u8d_pkg::CLS_LEAD2;
                entry.bits = {2'b00, data_byte[4:0]};
            end
            8'b1110????:
            begin
                entry.cls  = u8d_pkg::CLS_LEAD3;
                entry.bits = {3'b000, data_byte[3:0]};
            end
            8'b11110???:
            begin
                // four-byte lead is only legal while enabled
                entry.cls  = allow_four_byte_reg ? u8d_pkg::CLS_LEAD4 : u8d_pkg::CLS_BAD;
                entry.bits = {4'b0000, data_byte[2:0]};
            end
            default:
            begin
                entry.cls  = u8d_pkg::CLS_BAD;
                entry.bits = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/u8d_queue.sv =====
// short fifo of classified bytes between front and back end
`default_nettype none

module u8d_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8d_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output u8d_pkg::entry_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u8d_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u8d_back.sv =====
// back end: sequence state, code point assembly and the output register
`default_nettype none

`include "assert_macros.svh"

module u8d_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_not_empty,
    input  wire u8d_pkg::entry_t          q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [u8d_pkg::CP_W-1:0]      code_point,
    output logic                          decode_error,
    output logic                          string_done
);

    logic [1:0]                 pending_reg;
    logic [1:0]                 pending_next;
    logic [u8d_pkg::CP_W-1:0]   partial_reg;
    logic [u8d_pkg::CP_W-1:0]   partial_next;
    logic                       discarding_reg;
    logic                       discarding_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [u8d_pkg::CP_W-1:0]   code_point_reg;
    logic                       decode_error_reg;
    logic                       string_done_reg;
    logic [u8d_pkg::CP_W-1:0]   shifted;
    logic                       emit;
    logic                       emit_err;
    logic [u8d_pkg::CP_W-1:0]   emit_cp;

    // the output register frees a slot when it is empty or being taken
    assign q_pop   = q_not_empty && (!out_valid_reg || out_ready);
    assign shifted = {partial_reg[u8d_pkg::CP_W-7:0], q_head.bits[5:0]};

    assign out_valid    = out_valid_reg;
    assign code_point   = code_point_reg;
    assign decode_error = decode_error_reg;
    assign string_done  = string_done_reg;

    always_comb
    begin
        pending_next    = pending_reg;
        partial_next    = partial_reg;
        discarding_next = discarding_reg;
        emit            = 1'b0;
        emit_err        = 1'b0;
        emit_cp         = '0;
        if (q_pop)
        begin
            if (discarding_reg)
            begin
                if (q_head.eos)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (pending_reg != 2'd0)
            begin
                if (q_head.cls != u8d_pkg::CLS_CONT)
                begin
                    emit_err = 1'b1;
                end
                else if (pending_reg == 2'd1)
                begin
                    pending_next = 2'd0;
                    partial_next = '0;
                    emit         = 1'b1;
                    emit_cp      = shifted;
                end
                else if (q_head.eos)
                begin
                    // string ends mid-sequence
                    emit_err = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg - 2'd1;
                    partial_next = shifted;
                end
            end
            else
            begin
                case (q_head.cls)
                    u8d_pkg::CLS_ASCII:
                    begin
                        emit    = 1'b1;
                        emit_cp = u8d_pkg::CP_W'(q_head.bits);
                    end
                    u8d_pkg::CLS_LEAD2, u8d_pkg::CLS_LEAD3, u8d_pkg::CLS_LEAD4:
                    begin
                        if (q_head.eos)
                        begin
                            emit_err = 1'b1;
                        end
                        else
                        begin
                            partial_next = u8d_pkg::CP_W'(q_head.bits);
                            case (q_head.cls)
                                u8d_pkg::CLS_LEAD2: pending_next = 2'd1;
                                u8d_pkg::CLS_LEAD3: pending_next = 2'd2;
                                default:            pending_next = 2'd3;
                            endcase
                        end
                    end
                    default:
                    begin
                        emit_err = 1'b1;
                    end
                endcase
            end
            if (emit_err)
            begin
                emit            = 1'b1;
                emit_cp         = '0;
                pending_next    = 2'd0;
                partial_next    = '0;
                discarding_next = !q_head.eos;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 2'd0;
            partial_reg    <= '0;
            discarding_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            partial_reg    <= partial_next;
            discarding_reg <= discarding_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            code_point_reg   <= emit_cp;
            decode_error_reg <= emit_err;
            string_done_reg  <= q_head.eos;
        end
    end

    `ASSERT_NEVER(a_disc_idle, discarding_reg && (pending_reg != 2'd0),
        "discarding while a sequence is open")
    `ASSERT_CHECK(a_err_zero, out_valid_reg && decode_error_reg |-> code_point_reg == '0,
        "error result with nonzero code point")
    `ASSERT_NEVER(a_no_overrun, q_pop && out_valid_reg && !out_ready,
        "queue popped while result is stalled")

endmodule

`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
// an accepted byte is registered in the queue; the result it completes is then registered at the output
// throughput: one byte per cycle; output stalls fill the queue before in_ready drops
// the queue depth sets how many stall cycles the front end absorbs on its own
// reset: asynchronous active low; clears the sequence state, queue and output valid
// reset sets the four-byte enable to one
`default_nettype none

module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_allow_four_byte,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [u8d_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       end_of_string,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [u8d_pkg::CP_W-1:0]        code_point,
    output logic                            decode_error,
    output logic                            string_done
);

    u8d_pkg::entry_t front_entry;
    u8d_pkg::entry_t q_head;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;

    assign in_ready = !q_full;

    u8d_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_allow_four_byte (cfg_allow_four_byte),
        .data_byte           (data_byte),
        .end_of_string       (end_of_string),
        .entry               (front_entry)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !q_full),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    u8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_point   (code_point),
        .decode_error (decode_error),
        .string_done  (string_done)
    );

endmodule

`default_nettype wire

// ===== tb/sv/utf8_stream_decoder_tb.sv =====
// self-checking testbench for the streaming utf-8 decoder
module utf8_stream_decoder_tb;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 6;

    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0] cp;
        logic                     err;
        logic                     done;
    } decoded_char_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_allow_four_byte;
    logic                       in_valid;
    logic                       in_ready;
    logic [u8d_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_string;
    logic                       out_valid;
    logic                       out_ready;
    logic [u8d_pkg::CP_W-1:0]   code_point;
    logic                       decode_error;
    logic                       string_done;

    // decoder state as the testbench tracks it
    logic                       four_byte_en = 1'b1;
    logic [1:0]                 cont_left    = 2'd0;
    logic [u8d_pkg::CP_W-1:0]   cp_accum     = '0;
    logic                       skipping     = 1'b0;

    decoded_char_t              expected_chars[$];
    int                         errors        = 0;
    int                         quiet_cycles  = 0;
    bit                         idle_enable   = 1'b1;
    bit                         hold_request  = 1'b0;

    utf8_stream_decoder DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_allow_four_byte (cfg_allow_four_byte),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .end_of_string       (end_of_string),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .code_point          (code_point),
        .decode_error        (decode_error),
        .string_done         (string_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_char(input logic [u8d_pkg::CP_W-1:0] cp, input logic err,
                                      input logic done);
        decoded_char_t c;
        c.cp   = cp;
        c.err  = err;
        c.done = done;
        expected_chars.push_back(c);
    endfunction

    function automatic void reject_string(input logic eos);
        cont_left = 2'd0;
        cp_accum  = '0;
        skipping  = !eos;
        push_char('0, 1'b1, eos);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        if (skipping)
        begin
            if (eos)
                skipping = 1'b0;
            return;
        end
        if (cont_left != 2'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                reject_string(eos);
                return;
            end
            cp_accum  = {cp_accum[u8d_pkg::CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                push_char(cp_accum, 1'b0, eos);
                cp_accum = '0;
            end
            else if (eos)
                reject_string(eos);
            return;
        end
        if (!b[7])
        begin
            push_char(u8d_pkg::CP_W'(b), 1'b0, eos);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            cp_accum  = u8d_pkg::CP_W'(b[4:0]);
            cont_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            cp_accum  = u8d_pkg::CP_W'(b[3:0]);
            cont_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110 && four_byte_en)
        begin
            cp_accum  = u8d_pkg::CP_W'(b[2:0]);
            cont_left = 2'd3;
        end
        else
        begin
            reject_string(eos);
            return;
        end
        // a lead byte cannot end a string
        if (eos)
            reject_string(eos);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, eos);
    endtask

    // stop sending and let every request in flight come out
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_four_byte(input logic en);
        drain_pipeline();
        cfg_valid           <= 1'b1;
        cfg_allow_four_byte <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        four_byte_en = en;
    endtask

    task automatic test_single_byte_chars();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_multibyte_chars();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // largest value a four-byte lead can reach
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_bad_lead_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hE2, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_truncated_strings();
        send_byte(8'hC3, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b1);
    endtask

    task automatic test_four_byte_mode();
        set_four_byte(1'b0);
        send_byte(8'hF0, 1'b1);
        // switch mode in the middle of a three-byte sequence
        send_byte(8'hE2, 1'b0);
        set_four_byte(1'b1);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_output_backpressure();
        idle_enable  = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom_range(0, 127)), (i % 6) == 5);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_strings(input int byte_budget);
        logic [7:0] seq[$];
        logic [7:0] lead;
        int         sent;
        int         chars;
        int         r;
        sent = 0;
        while (sent < byte_budget)
        begin
            if ($urandom_range(0, 19) == 0)
                set_four_byte($urandom_range(0, 3) != 0);
            seq.delete();
            chars = $urandom_range(1, 8);
            for (int c = 0; c < chars; c++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    seq.push_back(8'($urandom_range(0, 255)));
                else if (r < 45)
                    seq.push_back(8'($urandom_range(0, 127)));
                else
                begin
                    if (r < 68)
                        lead = 8'hC0 | 8'($urandom_range(0, 31));
                    else if (r < 88)
                        lead = 8'hE0 | 8'($urandom_range(0, 15));
                    else
                        lead = 8'hF0 | 8'($urandom_range(0, 7));
                    seq.push_back(lead);
                    repeat ((r < 68) ? 1 : (r < 88) ? 2 : 3)
                        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
            end
            // break some strings: corrupt a byte, cut the tail or add a stray byte
            if ($urandom_range(0, 99) < 20)
            begin
                case ($urandom_range(0, 2))
                    0: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
                    1: if (seq.size() > 1) void'(seq.pop_back());
                    default: seq.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            foreach (seq[i])
                send_byte(seq[i], i == seq.size() - 1);
            sent += seq.size();
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        decoded_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: result with none expected, actual cp %0h err %b done %b",
                         $time, code_point, decode_error, string_done);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                check_field("code_point", 32'(want.cp), 32'(code_point));
                check_field("decode_error", 32'(want.err), 32'(decode_error));
                check_field("string_done", 32'(want.done), 32'(string_done));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idle_enable && $urandom_range(0, 99) < 25)
            begin
                out_ready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_chars.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_valid           <= 1'b0;
        cfg_allow_four_byte <= 1'b0;
        in_valid            <= 1'b0;
        data_byte           <= '0;
        end_of_string       <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_chars();
        test_multibyte_chars();
        test_bad_lead_bytes();
        test_bad_continuation();
        test_truncated_strings();
        test_four_byte_mode();
        test_output_backpressure();
        test_random_strings(230);
        idle_enable = 1'b0;
        test_random_strings(110);
        idle_enable = 1'b1;
        set_four_byte(1'b1);
        test_random_strings(140);

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_tb.sv
